// ===== hdl/yrgb_pkg.sv =====
`default_nettype none

package yrgb_pkg;

    // Fractional bits carried by every coefficient.
    localparam int COEF_FRAC_BITS = 13;

    localparam int COEF_W  = 16;
    localparam int PIX_W   = 8;
    localparam int PROD_W  = 25;
    // Luma, offset and two chroma terms stay well inside 27 signed bits.
    localparam int SUM_W   = 27;
    localparam int QUOT_W  = SUM_W - COEF_FRAC_BITS;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;
    localparam int ORDER_W = 2;

    localparam logic [PIX_W-1:0] PAD_OPAQUE = 8'hff;
    localparam logic [PIX_W-1:0] PAD_ZERO   = 8'h00;
    localparam logic [PIX_W-1:0] BYTE_MAX   = 8'hff;

    localparam logic [CNT_W-1:0] COUNT_FOUR  = 3'd4;
    localparam logic [CNT_W-1:0] COUNT_THREE = 3'd3;

    // Byte orders.
    localparam logic [ORDER_W-1:0] ORDER_BGRA = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_ARGB = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_BGR  = 2'd2;
    localparam logic [ORDER_W-1:0] ORDER_RGB  = 2'd3;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_LUMA_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LUMA_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_V_TO_RED    = 3'd2;
    localparam logic [IDX_W-1:0] REG_U_TO_GREEN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_V_TO_GREEN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_U_TO_BLUE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_PIXEL_ORDER = 3'd6;

    localparam logic signed [COEF_W-1:0] RST_LUMA_GAIN   = 16'sd9539;
    localparam logic signed [COEF_W-1:0] RST_LUMA_OFFSET = -16'sd582;
    localparam logic signed [COEF_W-1:0] RST_V_TO_RED    = 16'sd13075;
    localparam logic signed [COEF_W-1:0] RST_U_TO_GREEN  = -16'sd3209;
    localparam logic signed [COEF_W-1:0] RST_V_TO_GREEN  = -16'sd6660;
    localparam logic signed [COEF_W-1:0] RST_U_TO_BLUE   = 16'sd16525;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_coef               luma_gain;
        t_coef               luma_offset_coef;
        t_coef               v_to_red;
        t_coef               u_to_green;
        t_coef               v_to_green;
        t_coef               u_to_blue;
        logic [ORDER_W-1:0]  pixel_order;
    } t_cfg;

    // Drops the fraction and saturates to one byte.
    function automatic logic [PIX_W-1:0] clamp_byte(input t_sum sum);
        logic [QUOT_W-1:0] q;
        logic [PIX_W-1:0]  res;
        q = sum[SUM_W-1:COEF_FRAC_BITS];
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (q > QUOT_W'(BYTE_MAX)) begin
            res = BYTE_MAX;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/yrgb_cfg.sv =====
`default_nettype none

module yrgb_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [yrgb_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [yrgb_pkg::COEF_W-1:0] i_cfg_data,
    output yrgb_pkg::t_cfg                  o_cfg
);

    yrgb_pkg::t_cfg r_cfg;
    yrgb_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                yrgb_pkg::REG_LUMA_GAIN:   n_cfg.luma_gain        = i_cfg_data;
                yrgb_pkg::REG_LUMA_OFFSET: n_cfg.luma_offset_coef = i_cfg_data;
                yrgb_pkg::REG_V_TO_RED:    n_cfg.v_to_red         = i_cfg_data;
                yrgb_pkg::REG_U_TO_GREEN:  n_cfg.u_to_green       = i_cfg_data;
                yrgb_pkg::REG_V_TO_GREEN:  n_cfg.v_to_green       = i_cfg_data;
                yrgb_pkg::REG_U_TO_BLUE:   n_cfg.u_to_blue        = i_cfg_data;
                yrgb_pkg::REG_PIXEL_ORDER:
                    n_cfg.pixel_order = i_cfg_data[yrgb_pkg::ORDER_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_gain        <= yrgb_pkg::RST_LUMA_GAIN;
            r_cfg.luma_offset_coef <= yrgb_pkg::RST_LUMA_OFFSET;
            r_cfg.v_to_red         <= yrgb_pkg::RST_V_TO_RED;
            r_cfg.u_to_green       <= yrgb_pkg::RST_U_TO_GREEN;
            r_cfg.v_to_green       <= yrgb_pkg::RST_V_TO_GREEN;
            r_cfg.u_to_blue        <= yrgb_pkg::RST_U_TO_BLUE;
            r_cfg.pixel_order      <= yrgb_pkg::ORDER_BGRA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/yrgb_pipe.sv =====
`default_nettype none

module yrgb_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire yrgb_pkg::t_cfg              i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [yrgb_pkg::PIX_W-1:0]  i_luma,
    input  wire logic [yrgb_pkg::PIX_W-1:0]  i_chroma_u,
    input  wire logic [yrgb_pkg::PIX_W-1:0]  i_chroma_v,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [yrgb_pkg::PIX_W-1:0]       o_byte0,
    output logic [yrgb_pkg::PIX_W-1:0]       o_byte1,
    output logic [yrgb_pkg::PIX_W-1:0]       o_byte2,
    output logic [yrgb_pkg::PIX_W-1:0]       o_byte3,
    output logic [yrgb_pkg::CNT_W-1:0]       o_count
);

    logic en1;
    logic en2;
    logic en3;

    // Stage 1: the six products.
    logic                r_v1;
    yrgb_pkg::t_prod     r_p_luma;
    yrgb_pkg::t_prod     r_p_off;
    yrgb_pkg::t_prod     r_p_vr;
    yrgb_pkg::t_prod     r_p_ug;
    yrgb_pkg::t_prod     r_p_vg;
    yrgb_pkg::t_prod     r_p_ub;

    // Stage 2: channel sums.
    logic                r_v2;
    yrgb_pkg::t_sum      r_sum_r;
    yrgb_pkg::t_sum      r_sum_g;
    yrgb_pkg::t_sum      r_sum_b;

    // Stage 3: clamped and packed pixel.
    logic                              r_v3;
    logic [yrgb_pkg::PIX_W-1:0]        r_byte0;
    logic [yrgb_pkg::PIX_W-1:0]        r_byte1;
    logic [yrgb_pkg::PIX_W-1:0]        r_byte2;
    logic [yrgb_pkg::PIX_W-1:0]        r_byte3;
    logic [yrgb_pkg::CNT_W-1:0]        r_count;

    logic signed [yrgb_pkg::PIX_W:0]   luma_s;
    logic signed [yrgb_pkg::PIX_W-1:0] u_s;
    logic signed [yrgb_pkg::PIX_W-1:0] v_s;
    logic [yrgb_pkg::PIX_W-1:0]        red;
    logic [yrgb_pkg::PIX_W-1:0]        green;
    logic [yrgb_pkg::PIX_W-1:0]        blue;

    // A stage takes a new item when it is empty or its content moves on.
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // Removing the bias of 128 is an inversion of the top bit.
    assign luma_s = $signed({1'b0, i_luma});
    assign u_s    = $signed({~i_chroma_u[yrgb_pkg::PIX_W-1], i_chroma_u[yrgb_pkg::PIX_W-2:0]});
    assign v_s    = $signed({~i_chroma_v[yrgb_pkg::PIX_W-1], i_chroma_v[yrgb_pkg::PIX_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p_luma <= luma_s * i_cfg.luma_gain;
            r_p_off  <= i_cfg.luma_offset_coef * $signed(9'sd255);
            r_p_vr   <= v_s * i_cfg.v_to_red;
            r_p_ug   <= u_s * i_cfg.u_to_green;
            r_p_vg   <= v_s * i_cfg.v_to_green;
            r_p_ub   <= u_s * i_cfg.u_to_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_sum_r <= yrgb_pkg::SUM_W'(r_p_luma) + yrgb_pkg::SUM_W'(r_p_off)
                     + yrgb_pkg::SUM_W'(r_p_vr);
            r_sum_g <= yrgb_pkg::SUM_W'(r_p_luma) + yrgb_pkg::SUM_W'(r_p_off)
                     + yrgb_pkg::SUM_W'(r_p_ug) + yrgb_pkg::SUM_W'(r_p_vg);
            r_sum_b <= yrgb_pkg::SUM_W'(r_p_luma) + yrgb_pkg::SUM_W'(r_p_off)
                     + yrgb_pkg::SUM_W'(r_p_ub);
        end
    end

    assign red   = yrgb_pkg::clamp_byte(r_sum_r);
    assign green = yrgb_pkg::clamp_byte(r_sum_g);
    assign blue  = yrgb_pkg::clamp_byte(r_sum_b);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            unique case (i_cfg.pixel_order)
                yrgb_pkg::ORDER_BGRA: begin
                    r_byte0 <= blue;
                    r_byte1 <= green;
                    r_byte2 <= red;
                    r_byte3 <= yrgb_pkg::PAD_OPAQUE;
                    r_count <= yrgb_pkg::COUNT_FOUR;
                end
                yrgb_pkg::ORDER_ARGB: begin
                    // The pad byte repeats red.
                    r_byte0 <= red;
                    r_byte1 <= red;
                    r_byte2 <= green;
                    r_byte3 <= blue;
                    r_count <= yrgb_pkg::COUNT_FOUR;
                end
                yrgb_pkg::ORDER_BGR: begin
                    r_byte0 <= blue;
                    r_byte1 <= green;
                    r_byte2 <= red;
                    r_byte3 <= yrgb_pkg::PAD_ZERO;
                    r_count <= yrgb_pkg::COUNT_THREE;
                end
                default: begin
                    r_byte0 <= red;
                    r_byte1 <= green;
                    r_byte2 <= blue;
                    r_byte3 <= yrgb_pkg::PAD_ZERO;
                    r_count <= yrgb_pkg::COUNT_THREE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_byte0 = r_byte0;
    assign o_byte1 = r_byte1;
    assign o_byte2 = r_byte2;
    assign o_byte3 = r_byte3;
    assign o_count = r_count;

    a_three_byte_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_count == yrgb_pkg::COUNT_THREE) |-> r_byte3 == yrgb_pkg::PAD_ZERO)
        else $error("three-byte pixel with a non-zero fourth byte");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_count == yrgb_pkg::COUNT_THREE || r_count == yrgb_pkg::COUNT_FOUR))
        else $error("byte count out of range");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en2) |=> (r_v1 && $stable(r_p_luma) && $stable(r_p_vr)))
        else $error("stalled item lost in the product stage");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> (r_v2 && $stable(r_sum_g)))
        else $error("stalled item lost in the sum stage");

    a_no_bubble_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_v3) |-> o_ready)
        else $error("empty pipeline refuses input");

endmodule

`default_nettype wire

// ===== hdl/yuv444_to_rgb_converter.sv =====
// Channel   Direction  Handshake                   Payload
// s (pixel) in         i_s_tvalid / o_s_tready     i_s_tdata: luma, chroma_u, chroma_v
// m (pixel) out        o_m_tvalid / i_m_tready     o_m_tdata: bytes 0..3, byte_count
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Results come from the clamp-and-pack register; one item a cycle unless the output stalls.
// The stages are the multipliers, the channel adders and the clamp-and-pack register.
// Each stage holds its item under a stall and refills as soon as it empties.
// Reset is synchronous and active low; it empties the pipeline and loads the
// default BT.601 coefficients with BGRA order. Configuration writes are always accepted.
`default_nettype none

module yuv444_to_rgb_converter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [23:0]                   i_s_tdata,  // luma, chroma_u, chroma_v
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [39:0]                        o_m_tdata,  // out_byte0..3, byte_count, 0
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [yrgb_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [yrgb_pkg::COEF_W-1:0]   i_cfg_data
);

    yrgb_pkg::t_cfg                  cfg;
    logic [yrgb_pkg::PIX_W-1:0]      byte0;
    logic [yrgb_pkg::PIX_W-1:0]      byte1;
    logic [yrgb_pkg::PIX_W-1:0]      byte2;
    logic [yrgb_pkg::PIX_W-1:0]      byte3;
    logic [yrgb_pkg::CNT_W-1:0]      count;

    yrgb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    yrgb_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_luma     (i_s_tdata[7:0]),
        .i_chroma_u (i_s_tdata[15:8]),
        .i_chroma_v (i_s_tdata[23:16]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte0    (byte0),
        .o_byte1    (byte1),
        .o_byte2    (byte2),
        .o_byte3    (byte3),
        .o_count    (count)
    );

    assign o_m_tdata = {5'b0, count, byte3, byte2, byte1, byte0};

endmodule

`default_nettype wire
